// File: hw/rtl/tracker_pose_transform_defines.svh
// assertion macros for the tracker pose transform
`ifndef TRACKER_POSE_TRANSFORM_DEFINES_SVH
`define TRACKER_POSE_TRANSFORM_DEFINES_SVH

// checked outside reset
`define TPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tpt: pipeline check failed");

// checked while reset is held too
`define TPT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tpt: reset check failed");

`endif

// File: hw/rtl/tpt_pkg.sv
// shared types, constants and saturation helpers for the tracker pose transform
`timescale 1ns / 1ps

package tpt_pkg;

  localparam int NumStages = 7;
  localparam int StgLast   = NumStages - 1;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;

  localparam logic [CfgIdxW-1:0] RegFlags   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegScale   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOffsetX = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOffsetY = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOffsetZ = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRotOff  = 3'd5;

  localparam int FlagSwapYz = 3;
  localparam int FlagSwapXz = 4;
  localparam int FlagSwapXy = 5;

  typedef logic [NumStages-1:0] stage_en_t;
  typedef logic signed [31:0]   pos_t;
  typedef logic signed [15:0]   quat_t;

  typedef struct packed {
    logic [5:0]        flags;
    logic signed [31:0] scale;
    logic [2:0][31:0]  off;
    logic [63:0]       rot;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    flags: 6'd0,
    scale: 32'sd65536,
    off:   '0,
    rot:   64'd16384
  };

  function automatic pos_t neg_sat32(input pos_t v);
    if (v == 32'sh8000_0000) begin
      return 32'sh7fff_ffff;
    end
    return -v;
  endfunction

  function automatic pos_t sat32(input logic signed [59:0] v);
    if (v[59:31] == '0 || v[59:31] == '1) begin
      return v[31:0];
    end
    return v[59] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic quat_t sat16(input logic signed [19:0] v);
    if (v[19:15] == '0 || v[19:15] == '1) begin
      return v[15:0];
    end
    return v[19] ? 16'sh8000 : 16'sh7fff;
  endfunction

endpackage

// File: hw/rtl/tracker_pose_transform.sv
// top level of the tracker pose transform: stream ports, config registers, stage control
//
//  channel   | dir | handshake       | payload
//  ----------+-----+-----------------+------------------------------------------
//  s_axis    | in  | tvalid / tready | pose: pos x,y,z (Q16.16), quat w,x,y,z
//  m_axis    | out | tvalid / tready | transformed pose, same layout
//  cfg       | in  | cfg_we_i        | cfg_idx_i selects register, cfg_data_i
//
//  seven register stages, one pose per cycle while the output is not stalled
//  the slowest stage is a 16 x 40 or 26 x 32 multiply
//  reset clears the stage valid bits and loads the config registers with their defaults
//  a stall fills bubbles first, then holds every stage in place
`timescale 1ns / 1ps
`include "tracker_pose_transform_defines.svh"

module tracker_pose_transform (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // pos_x, pos_y, pos_z (32 each), quat_w, quat_x, quat_y, quat_z (16 each)
  input  logic [159:0]                 s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_pos_x, out_pos_y, out_pos_z (32 each), out_quat_w, x, y, z (16 each)
  output logic [159:0]                 m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [tpt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tpt_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int N = tpt_pkg::NumStages;

  // config registers
  tpt_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tpt_pkg::CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpt_pkg::RegFlags:   cfg_q.flags  <= cfg_data_i[5:0];
        tpt_pkg::RegScale:   cfg_q.scale  <= cfg_data_i[31:0];
        tpt_pkg::RegOffsetX: cfg_q.off[0] <= cfg_data_i[31:0];
        tpt_pkg::RegOffsetY: cfg_q.off[1] <= cfg_data_i[31:0];
        tpt_pkg::RegOffsetZ: cfg_q.off[2] <= cfg_data_i[31:0];
        tpt_pkg::RegRotOff:  cfg_q.rot    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valid bits and advance enables
  logic [N-1:0]       vld_q;
  logic [N-1:0]       vld_d;
  tpt_pkg::stage_en_t en;

  always_comb begin
    en[N-1] = !vld_q[N-1] || m_axis_tready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < N; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[N-1];

  // request unpacking
  tpt_pkg::pos_t  pos_in   [3];
  tpt_pkg::quat_t quat_in  [4];
  tpt_pkg::pos_t  pos_out  [3];
  tpt_pkg::quat_t quat_out [4];

  assign pos_in[0]  = s_axis_tdata[31:0];
  assign pos_in[1]  = s_axis_tdata[63:32];
  assign pos_in[2]  = s_axis_tdata[95:64];
  assign quat_in[0] = s_axis_tdata[111:96];
  assign quat_in[1] = s_axis_tdata[127:112];
  assign quat_in[2] = s_axis_tdata[143:128];
  assign quat_in[3] = s_axis_tdata[159:144];

  tpt_pos_path u_pos (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg_q),
    .pos_i (pos_in),
    .pos_o (pos_out)
  );

  tpt_quat_path u_quat (
    .clk_i  (clk_i),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .quat_i (quat_in),
    .quat_o (quat_out)
  );

  assign m_axis_tdata = {quat_out[3], quat_out[2], quat_out[1], quat_out[0],
                         pos_out[2], pos_out[1], pos_out[0]};

  `TPT_ASSERT(a_full_stall_blocks_input, (&vld_q) && !m_axis_tready |-> !s_axis_tready)
  `TPT_ASSERT(a_accept_enters_stage0, s_axis_tvalid && s_axis_tready |=> vld_q[0])
  `TPT_ASSERT(a_drain_no_phantom,
              m_axis_tvalid && m_axis_tready && !vld_q[N-2] |=> !m_axis_tvalid)
  `TPT_ASSERT_RST(a_reset_empties_pipe, !rst_ni |-> vld_q == '0)

endmodule

// File: hw/rtl/tpt_pos_path.sv
// position datapath: axis negation, rotation by offset quaternion, scale and translation
`timescale 1ns / 1ps

module tpt_pos_path (
  input  logic               clk_i,
  input  tpt_pkg::stage_en_t en_i,
  input  tpt_pkg::cfg_t      cfg_i,
  input  tpt_pkg::pos_t      pos_i [3],
  output tpt_pkg::pos_t      pos_o [3]
);

  logic signed [15:0] ow;
  logic signed [15:0] ov [3];

  assign ow    = cfg_i.rot[15:0];
  assign ov[0] = cfg_i.rot[31:16];
  assign ov[1] = cfg_i.rot[47:32];
  assign ov[2] = cfg_i.rot[63:48];

  // stage 0: axis negation
  tpt_pkg::pos_t p0_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en_i[0]) begin
        p0_q[i] <= cfg_i.flags[i] ? tpt_pkg::neg_sat32(pos_i[i]) : pos_i[i];
      end
    end
  end

  // stage 1: cross(v, p) partial products
  logic signed [47:0] ca_d [3];
  logic signed [47:0] cb_d [3];
  logic signed [47:0] ca_q [3];
  logic signed [47:0] cb_q [3];
  tpt_pkg::pos_t      p1_q [3];

  always_comb begin
    ca_d[0] = 48'(ov[1]) * 48'(p0_q[2]);
    cb_d[0] = 48'(ov[2]) * 48'(p0_q[1]);
    ca_d[1] = 48'(ov[2]) * 48'(p0_q[0]);
    cb_d[1] = 48'(ov[0]) * 48'(p0_q[2]);
    ca_d[2] = 48'(ov[0]) * 48'(p0_q[1]);
    cb_d[2] = 48'(ov[1]) * 48'(p0_q[0]);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en_i[1]) begin
        ca_q[i] <= ca_d[i];
        cb_q[i] <= cb_d[i];
        p1_q[i] <= p0_q[i];
      end
    end
  end

  // stage 2: t = round(2c / 2^10)
  logic signed [48:0] c_sum [3];
  logic signed [48:0] c_rnd [3];
  logic signed [39:0] t_d   [3];
  logic signed [39:0] t_q   [3];
  tpt_pkg::pos_t      p2_q  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_sum[i] = 49'(ca_q[i]) - 49'(cb_q[i]);
      c_rnd[i] = c_sum[i] + 49'sd256;
      t_d[i]   = c_rnd[i][48:9];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en_i[2]) begin
        t_q[i]  <= t_d[i];
        p2_q[i] <= p1_q[i];
      end
    end
  end

  // stage 3: w*t and cross(v, t) partial products
  logic signed [55:0] pw_d [3];
  logic signed [55:0] da_d [3];
  logic signed [55:0] db_d [3];
  logic signed [55:0] pw_q [3];
  logic signed [55:0] da_q [3];
  logic signed [55:0] db_q [3];
  tpt_pkg::pos_t      p3_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pw_d[i] = 56'(ow) * 56'(t_q[i]);
    end
    da_d[0] = 56'(ov[1]) * 56'(t_q[2]);
    db_d[0] = 56'(ov[2]) * 56'(t_q[1]);
    da_d[1] = 56'(ov[2]) * 56'(t_q[0]);
    db_d[1] = 56'(ov[0]) * 56'(t_q[2]);
    da_d[2] = 56'(ov[0]) * 56'(t_q[1]);
    db_d[2] = 56'(ov[1]) * 56'(t_q[0]);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en_i[3]) begin
        pw_q[i] <= pw_d[i];
        da_q[i] <= da_d[i];
        db_q[i] <= db_d[i];
        p3_q[i] <= p2_q[i];
      end
    end
  end

  // stage 4: r = p + round(u / 2^18)
  logic signed [57:0] u_sum [3];
  logic signed [57:0] u_rnd [3];
  logic signed [39:0] u_sh  [3];
  logic signed [41:0] r_d   [3];
  logic signed [41:0] r_q   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_sum[i] = 58'(pw_q[i]) + 58'(da_q[i]) - 58'(db_q[i]);
      u_rnd[i] = u_sum[i] + 58'sd131072;
      u_sh[i]  = u_rnd[i][57:18];
      r_d[i]   = 42'(p3_q[i]) + 42'(u_sh[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en_i[4]) begin
        r_q[i] <= r_d[i];
      end
    end
  end

  // stage 5: scale split into high and low halves of r
  logic signed [57:0] ph_d [3];
  logic signed [48:0] pl_d [3];
  logic signed [57:0] ph_q [3];
  logic signed [48:0] pl_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ph_d[i] = 58'($signed(r_q[i][41:16])) * 58'(cfg_i.scale);
      pl_d[i] = 49'($signed({1'b0, r_q[i][15:0]})) * 49'(cfg_i.scale);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en_i[5]) begin
        ph_q[i] <= ph_d[i];
        pl_q[i] <= pl_d[i];
      end
    end
  end

  // stage 6: round, translate, saturate
  logic signed [48:0] pl_rnd [3];
  logic signed [32:0] pl_sh  [3];
  logic signed [59:0] s_sum  [3];
  tpt_pkg::pos_t      out_d  [3];
  tpt_pkg::pos_t      out_q  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pl_rnd[i] = pl_q[i] + 49'sd32768;
      pl_sh[i]  = pl_rnd[i][48:16];
      s_sum[i]  = 60'(ph_q[i]) + 60'(pl_sh[i]) + 60'($signed(cfg_i.off[i]));
      out_d[i]  = tpt_pkg::sat32(s_sum[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en_i[tpt_pkg::StgLast]) begin
        out_q[i] <= out_d[i];
      end
    end
  end

  assign pos_o = out_q;

endmodule

// File: hw/rtl/tpt_quat_path.sv
// orientation datapath: component swaps and hamilton product with the offset quaternion
`timescale 1ns / 1ps

module tpt_quat_path (
  input  logic               clk_i,
  input  tpt_pkg::stage_en_t en_i,
  input  tpt_pkg::cfg_t      cfg_i,
  input  tpt_pkg::quat_t     quat_i [4],
  output tpt_pkg::quat_t     quat_o [4]
);

  tpt_pkg::quat_t o [4];

  assign o[0] = cfg_i.rot[15:0];
  assign o[1] = cfg_i.rot[31:16];
  assign o[2] = cfg_i.rot[47:32];
  assign o[3] = cfg_i.rot[63:48];

  // stage 0: pair swaps in order yz, xz, xy
  tpt_pkg::quat_t q_sw [4];
  tpt_pkg::quat_t q0_q [4];

  always_comb begin
    tpt_pkg::quat_t tmp;
    tmp  = '0;
    q_sw = quat_i;
    if (cfg_i.flags[tpt_pkg::FlagSwapYz]) begin
      tmp     = q_sw[2];
      q_sw[2] = q_sw[3];
      q_sw[3] = tmp;
    end
    if (cfg_i.flags[tpt_pkg::FlagSwapXz]) begin
      tmp     = q_sw[1];
      q_sw[1] = q_sw[3];
      q_sw[3] = tmp;
    end
    if (cfg_i.flags[tpt_pkg::FlagSwapXy]) begin
      tmp     = q_sw[1];
      q_sw[1] = q_sw[2];
      q_sw[2] = tmp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      q0_q <= q_sw;
    end
  end

  // stage 1: all sixteen component products
  logic signed [31:0] pr_q [4][4];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        if (en_i[1]) begin
          pr_q[j][k] <= 32'(q0_q[j]) * 32'(o[k]);
        end
      end
    end
  end

  // stage 2: sums, rounding, saturation
  logic signed [33:0] h_sum [4];
  logic signed [33:0] h_rnd [4];
  logic signed [19:0] h_sh  [4];
  tpt_pkg::quat_t     h_d   [4];

  always_comb begin
    h_sum[0] = 34'(pr_q[0][0]) - 34'(pr_q[1][1]) - 34'(pr_q[2][2]) - 34'(pr_q[3][3]);
    h_sum[1] = 34'(pr_q[0][1]) + 34'(pr_q[1][0]) + 34'(pr_q[2][3]) - 34'(pr_q[3][2]);
    h_sum[2] = 34'(pr_q[0][2]) - 34'(pr_q[1][3]) + 34'(pr_q[2][0]) + 34'(pr_q[3][1]);
    h_sum[3] = 34'(pr_q[0][3]) + 34'(pr_q[1][2]) - 34'(pr_q[2][1]) + 34'(pr_q[3][0]);
    for (int j = 0; j < 4; j++) begin
      h_rnd[j] = h_sum[j] + 34'sd8192;
      h_sh[j]  = h_rnd[j][33:14];
      h_d[j]   = tpt_pkg::sat16(h_sh[j]);
    end
  end

  // stages 2 to last: result travels alongside the position
  tpt_pkg::quat_t qd_q [2:tpt_pkg::StgLast][4];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      qd_q[2] <= h_d;
    end
    for (int s = 3; s <= tpt_pkg::StgLast; s++) begin
      if (en_i[s]) begin
        qd_q[s] <= qd_q[s-1];
      end
    end
  end

  assign quat_o = qd_q[tpt_pkg::StgLast];

endmodule

// File: verif/tracker_pose_transform_tb.sv
// self-checking testbench for the tracker pose transform stream block
`timescale 1ns / 1ps

module tracker_pose_transform_tb;

  localparam int QuietLimit = 2000;
  localparam int IdlePct    = 7;
  localparam int PhaseCount = 10;
  localparam int PhaseItems = 93;
  localparam int DrainWait  = 30;
  localparam int SinkHold   = 300;

  // indexes that decode to no register
  localparam logic [tpt_pkg::CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [tpt_pkg::CfgIdxW-1:0] RegSpareHi = 3'd7;

  localparam logic [15:0] QuatOne  = 16'h4000;
  localparam logic [15:0] QuatHalf = 16'h2d41;
  localparam logic [31:0] ScaleOne = 32'h0001_0000;

  // tdata layout, lowest bits last
  typedef struct packed {
    logic [15:0] qz;
    logic [15:0] qy;
    logic [15:0] qx;
    logic [15:0] qw;
    logic [31:0] pz;
    logic [31:0] py;
    logic [31:0] px;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [tpt_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [tpt_pkg::CfgDataW-1:0] cfg_data_i = '0;

  // local copy of the register file
  logic [5:0] flags_r = 6'd0;
  longint scale_r = 65536;
  longint off_r[3] = '{0, 0, 0};
  logic [63:0] rot_r = 64'd16384;

  pose_t pose_q[$];
  pose_t predicted_q[$];
  bit req_taken = 1'b0;
  int idle_pct = IdlePct;
  int sink_stall_len = 0;
  int sink_hold = 0;
  int quiet_cycles = 0;
  int poses_sent = 0;
  int poses_checked = 0;
  int mismatches = 0;
  int settings_used = 0;

  tracker_pose_transform DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // out_pos_x, out_pos_y, out_pos_z, out_quat_w, out_quat_x, out_quat_y, out_quat_z
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint rnd_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end
    if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  function automatic pose_t transform_pose(pose_t pin);
    longint p[3];
    longint q[4];
    longint o[4];
    longint c[3];
    longint t[3];
    longint d[3];
    longint h[4];
    longint op[3];
    longint sw, r, rl, rh, s;
    pose_t res;
    int i;
    p[0] = longint'(signed'(pin.px));
    p[1] = longint'(signed'(pin.py));
    p[2] = longint'(signed'(pin.pz));
    q[0] = longint'(signed'(pin.qw));
    q[1] = longint'(signed'(pin.qx));
    q[2] = longint'(signed'(pin.qy));
    q[3] = longint'(signed'(pin.qz));
    // flag bits 0..2 negate the position axes
    for (i = 0; i < 3; i++) begin
      if (flags_r[i]) begin
        p[i] = clamp(-p[i], 32);
      end
    end
    for (i = 0; i < 4; i++) begin
      o[i] = longint'(signed'(rot_r[16*i +: 16]));
    end
    if (flags_r[tpt_pkg::FlagSwapYz]) begin
      sw = q[2]; q[2] = q[3]; q[3] = sw;
    end
    if (flags_r[tpt_pkg::FlagSwapXz]) begin
      sw = q[1]; q[1] = q[3]; q[3] = sw;
    end
    if (flags_r[tpt_pkg::FlagSwapXy]) begin
      sw = q[1]; q[1] = q[2]; q[2] = sw;
    end
    c[0] = o[2] * p[2] - o[3] * p[1];
    c[1] = o[3] * p[0] - o[1] * p[2];
    c[2] = o[1] * p[1] - o[2] * p[0];
    for (i = 0; i < 3; i++) begin
      t[i] = rnd_shift(2 * c[i], 10);
    end
    d[0] = o[2] * t[2] - o[3] * t[1];
    d[1] = o[3] * t[0] - o[1] * t[2];
    d[2] = o[1] * t[1] - o[2] * t[0];
    for (i = 0; i < 3; i++) begin
      r = p[i] + rnd_shift(o[0] * t[i] + d[i], 18);
      rl = r & 64'hffff;
      rh = (r - rl) >>> 16;
      s = rh * scale_r + rnd_shift(rl * scale_r, 16);
      op[i] = clamp(s + off_r[i], 32);
    end
    h[0] = q[0] * o[0] - q[1] * o[1] - q[2] * o[2] - q[3] * o[3];
    h[1] = q[0] * o[1] + q[1] * o[0] + q[2] * o[3] - q[3] * o[2];
    h[2] = q[0] * o[2] - q[1] * o[3] + q[2] * o[0] + q[3] * o[1];
    h[3] = q[0] * o[3] + q[1] * o[2] - q[2] * o[1] + q[3] * o[0];
    res.px = 32'(op[0]);
    res.py = 32'(op[1]);
    res.pz = 32'(op[2]);
    res.qw = 16'(clamp(rnd_shift(h[0], 14), 16));
    res.qx = 16'(clamp(rnd_shift(h[1], 14), 16));
    res.qy = 16'(clamp(rnd_shift(h[2], 14), 16));
    res.qz = 16'(clamp(rnd_shift(h[3], 14), 16));
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] mismatch %s on result %0d: got %h expected %h",
               $time, what, poses_checked, got, want);
    end
  endtask

  task automatic check_pose(pose_t got, pose_t want);
    string names[7] = '{"pos_x", "pos_y", "pos_z", "quat_w", "quat_x", "quat_y", "quat_z"};
    logic [159:0] g;
    logic [159:0] w;
    int i;
    g = got;
    w = want;
    for (i = 0; i < 7; i++) begin
      if (i < 3 && g[32*i +: 32] != w[32*i +: 32]) begin
        report_mismatch(names[i], g[32*i +: 32], w[32*i +: 32]);
      end else if (i >= 3 && g[96+16*(i-3) +: 16] != w[96+16*(i-3) +: 16]) begin
        report_mismatch(names[i], 32'(g[96+16*(i-3) +: 16]), 32'(w[96+16*(i-3) +: 16]));
      end
    end
  endtask

  // monitor: requests in, results out
  always @(posedge clk_i) begin
    req_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (req_taken) begin
        predicted_q.push_back(transform_pose(s_axis_tdata));
        poses_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
        end else begin
          check_pose(m_axis_tdata, predicted_q.pop_front());
        end
        poses_checked++;
      end
      if (req_taken || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (req_taken || !s_axis_tvalid)) begin
      if (pose_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        s_axis_tdata <= pose_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with its own long hold-off
  always @(negedge clk_i) begin
    if (sink_stall_len > 0) begin
      sink_hold = sink_stall_len;
      sink_stall_len = 0;
    end
    if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    @(posedge rst_ni);
    while (quiet_cycles < QuietLimit) begin
      @(negedge clk_i);
    end
    $display("watchdog: no handshake for %0d cycles", QuietLimit);
    $display("Regression FAIL");
    $finish;
  end

  task automatic write_reg(logic [tpt_pkg::CfgIdxW-1:0] idx,
                           logic [tpt_pkg::CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      tpt_pkg::RegFlags:   flags_r = data[5:0];
      tpt_pkg::RegScale:   scale_r = longint'(signed'(data[31:0]));
      tpt_pkg::RegOffsetX: off_r[0] = longint'(signed'(data[31:0]));
      tpt_pkg::RegOffsetY: off_r[1] = longint'(signed'(data[31:0]));
      tpt_pkg::RegOffsetZ: off_r[2] = longint'(signed'(data[31:0]));
      tpt_pkg::RegRotOff:  rot_r = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // garbage above each register's width must be dropped
  task automatic apply_settings(logic [5:0] flags, logic [31:0] scale, logic [31:0] ox,
                                logic [31:0] oy, logic [31:0] oz, logic [63:0] rot);
    write_reg(tpt_pkg::RegFlags, {$urandom, 26'($urandom), flags});
    write_reg(tpt_pkg::RegScale, {$urandom, scale});
    write_reg(tpt_pkg::RegOffsetX, {$urandom, ox});
    write_reg(tpt_pkg::RegOffsetY, {$urandom, oy});
    write_reg(tpt_pkg::RegOffsetZ, {$urandom, oz});
    write_reg(tpt_pkg::RegRotOff, rot);
    write_reg(($urandom_range(1) != 0) ? RegSpareLo : RegSpareHi, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    while (pose_q.size() != 0 || s_axis_tvalid || predicted_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_pos(bit tame);
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return tame ? {{8{v[23]}}, v[23:0]} : v;
    endcase
  endfunction

  function automatic logic [15:0] pick_quat(bit tame);
    int v;
    v = $urandom_range(32768);
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      default: return tame ? 16'(v - 16384) : 16'($urandom);
    endcase
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    bit tame;
    tame = $urandom_range(99) < 60;
    p.px = pick_pos(tame);
    p.py = pick_pos(tame);
    p.pz = pick_pos(tame);
    p.qw = pick_quat(tame);
    p.qx = pick_quat(tame);
    p.qy = pick_quat(tame);
    p.qz = pick_quat(tame);
    return p;
  endfunction

  function automatic logic [63:0] random_rotation();
    logic [15:0] a;
    logic [15:0] b;
    a = pick_quat(1'b1);
    b = pick_quat(1'b1);
    case ($urandom_range(5))
      0: return {48'd0, QuatOne};
      1: return {QuatHalf, 32'd0, QuatHalf};
      2: return {32'd0, QuatOne, 16'd0};
      3: return {48'd0, -QuatOne};
      4: return {b, a, pick_quat(1'b1), pick_quat(1'b1)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_edge_poses();
    logic [31:0] e32[5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, ScaleOne};
    logic [15:0] e16[5] = '{16'h8000, 16'h7fff, 16'h0, 16'hffff, QuatOne};
    pose_t p;
    int k;
    for (k = 0; k < 12; k++) begin
      p.px = e32[k % 5];
      p.py = e32[(k + 1) % 5];
      p.pz = e32[(k + 3) % 5];
      p.qw = e16[k % 5];
      p.qx = e16[(k + 2) % 5];
      p.qy = e16[(k + 4) % 5];
      p.qz = e16[(k + 1) % 5];
      pose_q.push_back(p);
    end
  endtask

  initial begin
    int ph;
    int n;
    #1 rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // edge values under the reset settings, then with every flag and a negative scale
    queue_edge_poses();
    wait_drained();
    apply_settings(6'h3f, 32'hffff_0000, 32'h0, 32'h7fff_ffff, 32'h8000_0000,
                   {QuatHalf, 32'd0, QuatHalf});
    queue_edge_poses();
    wait_drained();

    for (ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: apply_settings(6'h0, ScaleOne, '0, '0, '0, {48'd0, QuatOne});
        1: apply_settings(6'h3f, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          {4{16'h7fff}});
        2: apply_settings(6'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          {4{16'h8000}});
        3: apply_settings(6'($urandom), 32'h0, pick_pos(1'b1), pick_pos(1'b1),
                          pick_pos(1'b1), random_rotation());
        default: apply_settings(6'($urandom),
                                ($urandom_range(1) != 0) ? pick_pos(1'b0)
                                                         : 32'($urandom_range(131072)) - ScaleOne,
                                pick_pos(1'b1), pick_pos(1'b1), pick_pos(1'b1),
                                random_rotation());
      endcase
      // one phase runs flat out on both sides
      idle_pct = (ph == 3) ? 0 : IdlePct;
      for (n = 0; n < PhaseItems; n++) begin
        pose_q.push_back(random_pose());
      end
      if (ph == 5) begin
        sink_stall_len = SinkHold;
      end
      wait_drained();
    end

    repeat (DrainWait) @(negedge clk_i);
    $display("%0d poses sent, %0d results checked, %0d mismatches", poses_sent,
             poses_checked, mismatches);
    $display("%0d register settings incl. saturating extremes, flag swaps and a long output stall",
             settings_used);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
